// ===== sv/cholesky_spd_matrix_inverse_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Cholesky SPD matrix inverse
// Shared helpers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef CHOLESKY_SPD_MATRIX_INVERSE_DEFINES_SVH
`define CHOLESKY_SPD_MATRIX_INVERSE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CSMI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CSMI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/csmi_pkg.sv =====
// ----------------------------------------------------------------------------
// csmi_pkg
// Types, constants and saturation helpers for the matrix inverse block.
// ----------------------------------------------------------------------------
package csmi_pkg;

	localparam int DATA_W = 32;
	localparam int ACC_W  = 64;
	localparam int SIZE_W = 4;
	localparam int POS_W  = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam acc_t MAX32 = 64'sd2147483647;
	localparam acc_t MIN32 = -64'sd2147483648;

	// operation of the shared divide / square-root unit
	typedef enum logic {
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} unit_sts_t;

	// clip a wide value to 32 bits
	function automatic data_t sat32(input acc_t v);
		if (v > MAX32) begin
			return data_t'(MAX32);
		end else if (v < MIN32) begin
			return data_t'(MIN32);
		end
		return data_t'(v);
	endfunction

	function automatic logic sat32_ovf(input acc_t v);
		return (v > MAX32) || (v < MIN32);
	endfunction

endpackage

// ===== sv/csmi_if.sv =====
// ----------------------------------------------------------------------------
// csmi interfaces
// Valid/ready channels for configuration, matrix elements and results.
// ----------------------------------------------------------------------------
interface csmi_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [csmi_pkg::SIZE_W-1:0]      matrix_size;
	modport source (output valid, matrix_size, input ready);
	modport sink (input valid, matrix_size, output ready);
endinterface

interface csmi_in_if;
	logic            valid;
	logic            ready;
	csmi_pkg::data_t element_value;
	modport source (output valid, element_value, input ready);
	modport sink (input valid, element_value, output ready);
endinterface

interface csmi_out_if;
	logic                        valid;
	logic                        ready;
	csmi_pkg::data_t             inverse_value;
	logic [csmi_pkg::POS_W-1:0]  out_row;
	logic [csmi_pkg::POS_W-1:0]  out_col;
	logic                        last_of_run;
	logic                        not_pos_definite;
	logic                        saturated;
	modport source (output valid, inverse_value, out_row, out_col, last_of_run,
		not_pos_definite, saturated, input ready);
	modport sink (input valid, inverse_value, out_row, out_col, last_of_run,
		not_pos_definite, saturated, output ready);
endinterface

// ===== sv/cholesky_spd_matrix_inverse.sv =====
// ----------------------------------------------------------------------------
// cholesky_spd_matrix_inverse
// Fixed-point inverse of a symmetric positive definite matrix via an upper
// Cholesky factor, its inverse, and the product of that inverse with its
// transpose.
// ----------------------------------------------------------------------------
// Elements load one per cycle while ready is high, row-major, n*n of them (n
// from matrix_size). After the last one the block drops ready and runs the
// multiply-accumulate sweeps on one 32x32 multiplier, each term taking a read,
// a multiply and an accumulate step, plus n^2 divisions and up to n roots in
// the shared bit-serial divide/root unit. The n*n results then leave one at a
// time, each read from the store and held until the sink takes it, after
// which loading resumes.
// ----------------------------------------------------------------------------
`include "cholesky_spd_matrix_inverse_defines.svh"

module cholesky_spd_matrix_inverse #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	csmi_cfg_if.sink   cfg,
	csmi_in_if.sink    element,
	csmi_out_if.source inverse
);

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam int MAG_W  = FRAC_BITS + 32;
	localparam int POS_W  = csmi_pkg::POS_W;
	localparam int SIZE_W = csmi_pkg::SIZE_W;
	localparam csmi_pkg::acc_t RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic [MAG_W-1:0] RECIP_NUM = MAG_W'(1) << (2 * FRAC_BITS);

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [POS_W-1:0]  pos_t;

	typedef enum logic [3:0] {
		S_LOAD, S_RD, S_MUL, S_ACC, S_FIN, S_SQRT_W, S_RECIP_W, S_DIV_W,
		S_OUT_RD, S_OUT_LD, S_OUT_W
	} state_t;

	typedef enum logic [1:0] {
		PH_FACT, PH_INV, PH_PROD
	} phase_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [SIZE_W-1:0]   size_q;
	cnt_t                ld_r_q, ld_c_q, i_q, j_q, k_q;
	csmi_pkg::acc_t      acc_q, prod_q;
	logic                npd_q, sat_q;
	logic                ov_q, olast_q;
	csmi_pkg::data_t     oval_q;
	pos_t                orow_q, ocol_q;

	csmi_pkg::data_t     diag_q [MAX_DIM];
	csmi_pkg::data_t     in_mem_q [DEPTH];
	csmi_pkg::data_t     c_mem_q [DEPTH];
	csmi_pkg::data_t     d_mem_q [DEPTH];
	csmi_pkg::data_t     in_rd_q, c_rd1_q, c_rd2_q, d_rd1_q, d_rd2_q;

	cnt_t                n_eff, nm1, kend;
	idx_t                i_x, j_x, k_x, diag_idx, mn_x, mx_x;
	logic                ld_last, is_diag;
	csmi_pkg::data_t     a_op, b_op, piv;
	csmi_pkg::acc_t      mul_w, rnd, diff, neg_acc;
	csmi_pkg::data_t     x_sat, n_sat, p_sat, src, rfix;
	logic                x_ovf, n_ovf, p_ovf, x_pos;
	logic [31:0]         op_mag;

	csmi_pkg::unit_ctl_t u_ctl;
	csmi_pkg::unit_sts_t u_sts;
	logic [MAG_W-1:0]    u_num;
	logic                u_neg;
	logic [31:0]         u_den;
	csmi_pkg::data_t     u_res;

	logic                in_we, c_we, d_we, diag_we;
	addr_t               in_wa, in_ra, c_wa, d_wa;
	csmi_pkg::data_t     in_wd, c_wd, d_wd;

	logic [CNT_W:0]      i_p1, i_p2, j_p1, n_x;
	phase_t              nxt_phase;
	cnt_t                nxt_i, nxt_j, nxt_k;
	logic                run_done, elem_done, in_xfer;

	// effective dimension: zero acts as one, clipped at MAX_DIM
	always_comb begin
		if (size_q == '0) begin
			n_eff = cnt_t'(1);
		end else if (32'(size_q) > MAX_DIM) begin
			n_eff = cnt_t'(MAX_DIM);
		end else begin
			n_eff = cnt_t'(size_q);
		end
	end
	assign nm1 = n_eff - cnt_t'(1);

	assign i_x      = i_q[IDX_W-1:0];
	assign j_x      = j_q[IDX_W-1:0];
	assign k_x      = k_q[IDX_W-1:0];
	assign mn_x     = (i_q < j_q) ? i_x : j_x;
	assign mx_x     = (i_q < j_q) ? j_x : i_x;
	assign is_diag  = i_q == j_q;
	assign ld_last  = (ld_r_q == nm1) && (ld_c_q == nm1);
	assign in_xfer  = element.valid && element.ready;
	assign diag_idx = (phase_q == PH_FACT) ? i_x : j_x;
	assign piv      = diag_q[diag_idx];

	// end of the inner sum for each phase
	always_comb begin
		case (phase_q)
			PH_FACT: kend = i_q;
			PH_INV:  kend = j_q;
			PH_PROD: kend = n_eff;
			default: kend = n_eff;
		endcase
	end

	// multiply, round and saturate
	assign a_op    = (phase_q == PH_FACT) ? c_rd1_q : d_rd1_q;
	assign b_op    = (phase_q == PH_PROD) ? d_rd2_q : c_rd2_q;
	assign mul_w   = a_op * b_op;
	assign rnd     = (prod_q + RND_HALF) >>> FRAC_BITS;
	assign diff    = csmi_pkg::acc_t'(in_rd_q) - acc_q;
	assign neg_acc = -acc_q;
	assign x_sat   = csmi_pkg::sat32(diff);
	assign x_ovf   = csmi_pkg::sat32_ovf(diff);
	assign n_sat   = csmi_pkg::sat32(neg_acc);
	assign n_ovf   = csmi_pkg::sat32_ovf(neg_acc);
	assign p_sat   = csmi_pkg::sat32(acc_q);
	assign p_ovf   = csmi_pkg::sat32_ovf(acc_q);
	assign x_pos   = x_sat > 32'sd0;
	assign src     = (phase_q == PH_INV) ? n_sat : x_sat;
	assign op_mag  = src[31] ? 32'(-src) : 32'(src);
	assign rfix    = (u_res < 32'sd1) ? 32'sd1 : u_res;

	// requests to the divide / root unit
	always_comb begin
		u_ctl.start = 1'b0;
		u_ctl.op    = csmi_pkg::OP_DIV;
		u_num       = {op_mag, {FRAC_BITS{1'b0}}};
		u_neg       = src[31];
		u_den       = 32'(piv);
		if (state_q == S_FIN && phase_q == PH_FACT && is_diag) begin
			u_ctl.start = 1'b1;
			if (x_pos) begin
				u_ctl.op = csmi_pkg::OP_SQRT;
				u_num    = {1'b0, x_sat[30:0], {FRAC_BITS{1'b0}}};
			end else begin
				u_num = RECIP_NUM;
				u_neg = 1'b0;
				u_den = 32'd1;
			end
		end else if (state_q == S_FIN && phase_q != PH_PROD) begin
			u_ctl.start = 1'b1;
		end else if (state_q == S_SQRT_W && u_sts.done) begin
			u_ctl.start = 1'b1;
			u_num       = RECIP_NUM;
			u_neg       = 1'b0;
			u_den       = 32'(rfix);
		end
	end

	csmi_divsqrt #(
		.FRAC_BITS (FRAC_BITS)
	) u_divsqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (u_ctl),
		.num_mag (u_num),
		.num_neg (u_neg),
		.den     (u_den),
		.sts     (u_sts),
		.res     (u_res)
	);

	// memory write selection
	always_comb begin
		in_we   = 1'b0;
		in_wa   = {i_x, j_x};
		in_wd   = p_sat;
		c_we    = 1'b0;
		c_wa    = {i_x, j_x};
		c_wd    = u_res;
		d_we    = 1'b0;
		d_wa    = {i_x, j_x};
		d_wd    = u_res;
		diag_we = 1'b0;
		if (state_q == S_LOAD && in_xfer) begin
			in_we = 1'b1;
			in_wa = {ld_r_q[IDX_W-1:0], ld_c_q[IDX_W-1:0]};
			in_wd = element.element_value;
		end else if (state_q == S_FIN && phase_q == PH_PROD) begin
			in_we = 1'b1;
		end
		if (state_q == S_FIN && phase_q == PH_FACT && is_diag && !x_pos) begin
			c_we    = 1'b1;
			c_wd    = 32'sd1;
			diag_we = 1'b1;
		end else if (state_q == S_SQRT_W && u_sts.done) begin
			c_we    = 1'b1;
			c_wd    = rfix;
			diag_we = 1'b1;
		end else if (state_q == S_DIV_W && u_sts.done && phase_q == PH_FACT) begin
			c_we = 1'b1;
		end
		if (state_q == S_RECIP_W && u_sts.done) begin
			d_we = 1'b1;
		end else if (state_q == S_DIV_W && u_sts.done && phase_q == PH_INV) begin
			d_we = 1'b1;
		end
	end

	assign in_ra = (state_q == S_OUT_RD || state_q == S_OUT_LD || state_q == S_OUT_W)
		? {mn_x, mx_x} : {i_x, j_x};

	// input store, reused for the upper triangle of the inverse
	always_ff @(posedge clk) begin
		if (in_we) begin
			in_mem_q[in_wa] <= in_wd;
		end
		in_rd_q <= in_mem_q[in_ra];
	end

	// Cholesky factor store
	always_ff @(posedge clk) begin
		if (c_we) begin
			c_mem_q[c_wa] <= c_wd;
		end
		c_rd1_q <= c_mem_q[{k_x, i_x}];
		c_rd2_q <= c_mem_q[{k_x, j_x}];
	end

	// inverse factor store
	always_ff @(posedge clk) begin
		if (d_we) begin
			d_mem_q[d_wa] <= d_wd;
		end
		d_rd1_q <= d_mem_q[{i_x, k_x}];
		d_rd2_q <= d_mem_q[{j_x, k_x}];
	end

	// factor diagonal kept aside as divisor
	always_ff @(posedge clk) begin
		if (diag_we) begin
			diag_q[i_x] <= c_wd;
		end
	end

	// next element of the triangular sweeps
	assign i_p1 = {1'b0, i_q} + 1'b1;
	assign i_p2 = {1'b0, i_q} + 2'd2;
	assign j_p1 = {1'b0, j_q} + 1'b1;
	assign n_x  = {1'b0, n_eff};

	always_comb begin
		nxt_phase = phase_q;
		nxt_i     = i_q;
		nxt_j     = j_q;
		run_done  = 1'b0;
		if (j_p1 < n_x) begin
			nxt_j = j_p1[CNT_W-1:0];
		end else begin
			case (phase_q)
				PH_FACT: begin
					if (i_p1 < n_x) begin
						nxt_i = i_p1[CNT_W-1:0];
						nxt_j = i_p1[CNT_W-1:0];
					end else if (n_eff > cnt_t'(1)) begin
						nxt_phase = PH_INV;
						nxt_i     = '0;
						nxt_j     = cnt_t'(1);
					end else begin
						nxt_phase = PH_PROD;
						nxt_i     = '0;
						nxt_j     = '0;
					end
				end
				PH_INV: begin
					if (i_p2 < n_x) begin
						nxt_i = i_p1[CNT_W-1:0];
						nxt_j = i_p2[CNT_W-1:0];
					end else begin
						nxt_phase = PH_PROD;
						nxt_i     = '0;
						nxt_j     = '0;
					end
				end
				PH_PROD: begin
					if (i_p1 < n_x) begin
						nxt_i = i_p1[CNT_W-1:0];
						nxt_j = i_p1[CNT_W-1:0];
					end else begin
						run_done = 1'b1;
					end
				end
				default: run_done = 1'b1;
			endcase
		end
		case (nxt_phase)
			PH_FACT: nxt_k = '0;
			PH_INV:  nxt_k = nxt_i;
			PH_PROD: nxt_k = nxt_j;
			default: nxt_k = '0;
		endcase
	end

	assign elem_done = (state_q == S_FIN && phase_q == PH_PROD)
		|| ((state_q == S_RECIP_W || state_q == S_DIV_W) && u_sts.done);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			phase_q <= PH_FACT;
			size_q  <= SIZE_W'(3);
			ld_r_q  <= '0;
			ld_c_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			acc_q   <= '0;
			prod_q  <= '0;
			npd_q   <= 1'b0;
			sat_q   <= 1'b0;
			ov_q    <= 1'b0;
			olast_q <= 1'b0;
			oval_q  <= '0;
			orow_q  <= '0;
			ocol_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				size_q <= cfg.matrix_size;
				ld_r_q <= '0;
				ld_c_q <= '0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_xfer) begin
						if (ld_last) begin
							ld_r_q  <= '0;
							ld_c_q  <= '0;
							state_q <= S_RD;
							phase_q <= PH_FACT;
							i_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
							acc_q   <= '0;
							npd_q   <= 1'b0;
							sat_q   <= 1'b0;
						end else if (ld_c_q == nm1) begin
							ld_c_q <= '0;
							ld_r_q <= ld_r_q + 1'b1;
						end else begin
							ld_c_q <= ld_c_q + 1'b1;
						end
					end
				end
				S_RD: begin
					state_q <= (k_q == kend) ? S_FIN : S_MUL;
				end
				S_MUL: begin
					prod_q  <= mul_w;
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q   <= acc_q + rnd;
					k_q     <= k_q + 1'b1;
					state_q <= S_RD;
				end
				S_FIN: begin
					case (phase_q)
						PH_FACT: begin
							sat_q <= sat_q | x_ovf;
							if (!is_diag) begin
								state_q <= S_DIV_W;
							end else if (x_pos) begin
								state_q <= S_SQRT_W;
							end else begin
								npd_q   <= 1'b1;
								state_q <= S_RECIP_W;
							end
						end
						PH_INV: begin
							sat_q   <= sat_q | n_ovf;
							state_q <= S_DIV_W;
						end
						PH_PROD: sat_q <= sat_q | p_ovf;
						default: state_q <= S_LOAD;
					endcase
				end
				S_SQRT_W: begin
					if (u_sts.done) begin
						state_q <= S_RECIP_W;
					end
				end
				S_RECIP_W, S_DIV_W: begin
					if (u_sts.done) begin
						sat_q <= sat_q | u_sts.ovf;
					end
				end
				S_OUT_RD: state_q <= S_OUT_LD;
				S_OUT_LD: begin
					ov_q    <= 1'b1;
					oval_q  <= in_rd_q;
					orow_q  <= pos_t'(i_q);
					ocol_q  <= pos_t'(j_q);
					olast_q <= (i_q == nm1) && (j_q == nm1);
					state_q <= S_OUT_W;
				end
				S_OUT_W: begin
					if (inverse.ready) begin
						ov_q <= 1'b0;
						if (j_q != nm1) begin
							j_q     <= j_q + 1'b1;
							state_q <= S_OUT_RD;
						end else if (i_q != nm1) begin
							i_q     <= i_q + 1'b1;
							j_q     <= '0;
							state_q <= S_OUT_RD;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
			// move on once an element is stored
			if (elem_done) begin
				acc_q <= '0;
				if (run_done) begin
					i_q     <= '0;
					j_q     <= '0;
					state_q <= S_OUT_RD;
				end else begin
					phase_q <= nxt_phase;
					i_q     <= nxt_i;
					j_q     <= nxt_j;
					k_q     <= nxt_k;
					state_q <= S_RD;
				end
			end
		end
	end

	// size writes only between runs; a pending size write holds off elements
	assign cfg.ready                = state_q == S_LOAD;
	assign element.ready            = (state_q == S_LOAD) && !cfg.valid;
	assign inverse.valid            = ov_q;
	assign inverse.inverse_value    = oval_q;
	assign inverse.out_row          = orow_q;
	assign inverse.out_col          = ocol_q;
	assign inverse.last_of_run      = olast_q;
	assign inverse.not_pos_definite = npd_q;
	assign inverse.saturated        = sat_q;

	`CSMI_ASSERT_NOW(a_no_load_during_out, clk, arst_n, element.ready, !inverse.valid, "element ready while a result is pending")
	`CSMI_ASSERT_NOW(a_unit_done_waited, clk, arst_n, u_sts.done, (state_q == S_SQRT_W || state_q == S_RECIP_W || state_q == S_DIV_W), "divide/root result with no waiting step")
	`CSMI_ASSERT_NOW(a_last_at_corner, clk, arst_n, inverse.valid && inverse.last_of_run, (inverse.out_row == pos_t'(nm1) && inverse.out_col == pos_t'(nm1)), "last result not at the last row and column")
	`CSMI_ASSERT_NEXT(a_run_starts_clean, clk, arst_n, in_xfer && ld_last, (state_q == S_RD && !npd_q && !sat_q), "run did not start with cleared flags")

endmodule

// ===== sv/csmi_divsqrt.sv =====
// ----------------------------------------------------------------------------
// csmi_divsqrt
// Bit-serial unit: rounded signed division with 32-bit saturation, or
// floor square root. One quotient bit or one root bit per cycle.
// ----------------------------------------------------------------------------
module csmi_divsqrt #(
	parameter int FRAC_BITS = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  csmi_pkg::unit_ctl_t     ctl,
	input  logic [FRAC_BITS+31:0]   num_mag,
	input  logic                    num_neg,
	input  logic [31:0]             den,
	output csmi_pkg::unit_sts_t     sts,
	output csmi_pkg::data_t         res
);

	localparam int MAG_W     = FRAC_BITS + 32;
	localparam int SQ_W      = MAG_W + (MAG_W % 2);
	localparam int SQ_STEPS  = SQ_W / 2;
	localparam int CNT_W     = $clog2(MAG_W + 1);
	localparam logic [MAG_W-1:0] POS_LIM = MAG_W'(64'h7fffffff);
	localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'h80000000);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);
	localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(SQ_STEPS - 1);

	logic                   busy_q, fin_q, done_q, ovf_q;
	csmi_pkg::unit_op_t     op_q;
	logic                   neg_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [31:0]            den_q, rem_q;
	logic [MAG_W-1:0]       dvd_q, quo_q;
	logic [SQ_W-1:0]        srem_q, root_q, sbit_q;
	csmi_pkg::data_t        res_q;

	logic [32:0]            rem_sh, rem_sub;
	logic                   div_ge, s_ge, last_step, take;
	logic [SQ_W-1:0]        s_sum;

	// one restoring-division step and one root step
	assign rem_sh    = {rem_q, dvd_q[MAG_W-1]};
	assign div_ge    = rem_sh >= {1'b0, den_q};
	assign rem_sub   = rem_sh - {1'b0, den_q};
	assign s_sum     = root_q + sbit_q;
	assign s_ge      = srem_q >= s_sum;
	assign last_step = (op_q == csmi_pkg::OP_DIV) ? (cnt_q == DIV_LAST) : (cnt_q == SQ_LAST);
	assign take      = ctl.start && !busy_q && !fin_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= ctl.op;
			neg_q  <= num_neg;
			den_q  <= den;
			dvd_q  <= num_mag + MAG_W'(den >> 1);
			rem_q  <= '0;
			quo_q  <= '0;
			srem_q <= SQ_W'(num_mag);
			root_q <= '0;
			sbit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (op_q == csmi_pkg::OP_DIV) begin
				rem_q <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
				quo_q <= {quo_q[MAG_W-2:0], div_ge};
				dvd_q <= dvd_q << 1;
			end else begin
				if (s_ge) begin
					srem_q <= srem_q - s_sum;
					root_q <= (root_q >> 1) + sbit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
		end else if (fin_q) begin
			ovf_q <= 1'b0;
			if (op_q == csmi_pkg::OP_SQRT) begin
				res_q <= csmi_pkg::data_t'(root_q[31:0]);
			end else if (!neg_q) begin
				if (quo_q > POS_LIM) begin
					res_q <= csmi_pkg::data_t'(POS_LIM[31:0]);
					ovf_q <= 1'b1;
				end else begin
					res_q <= csmi_pkg::data_t'(quo_q[31:0]);
				end
			end else begin
				if (quo_q > NEG_LIM) begin
					res_q <= csmi_pkg::data_t'(NEG_LIM[31:0]);
					ovf_q <= 1'b1;
				end else begin
					res_q <= csmi_pkg::data_t'(-quo_q[31:0]);
				end
			end
		end
	end

	assign sts = '{done: done_q, ovf: ovf_q};
	assign res = res_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for cholesky_spd_matrix_inverse
// Streams matrices of every size and shape into the block and predicts each
// inverse in fixed point. Every result transfer is checked field by field
// against the oldest predicted inverse element.
// ----------------------------------------------------------------------------
module tb;

	localparam int    DIM      = 8;
	localparam int    FRAC     = 20;
	localparam longint ONE_FX  = 64'sd1 << FRAC;
	localparam longint HI32    = 64'sd2147483647;
	localparam longint LO32    = -64'sd2147483648;

	typedef struct {
		csmi_pkg::data_t                value;
		logic [csmi_pkg::POS_W-1:0]     row;
		logic [csmi_pkg::POS_W-1:0]     col;
		logic                           last;
		logic                           npd;
		logic                           sat;
	} inv_elem_t;

	logic clk;
	logic arst_n;

	csmi_cfg_if cfg_ch ();
	csmi_in_if  elem_ch ();
	csmi_out_if inv_ch ();

	cholesky_spd_matrix_inverse dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.element (elem_ch),
		.inverse (inv_ch)
	);

	// predicted state of the block
	longint    a_mat [DIM*DIM];
	longint    chol [DIM*DIM];
	longint    chol_inv [DIM*DIM];
	int        size_reg = 3;
	int        loaded = 0;
	bit        sat_seen;
	bit        npd_seen;
	inv_elem_t expected_inverse [$];

	int  errors = 0;
	int  elems_sent = 0;
	int  sink_hold = 0;
	bit  steady = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// ---------------- fixed-point predictor ----------------
	function automatic longint clip32(input longint v);
		if (v > HI32) begin
			sat_seen = 1;
			return HI32;
		end
		if (v < LO32) begin
			sat_seen = 1;
			return LO32;
		end
		return v;
	endfunction

	// exact product rounded half up to FRAC fraction bits
	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + (64'sd1 << (FRAC - 1))) >>> FRAC;
	endfunction

	// round half away from zero, den > 0
	function automatic longint round_div(input longint num, input longint den);
		longint m, q;
		m = num < 0 ? -num : num;
		q = (m + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint fx_div(input longint num, input longint den);
		return clip32(round_div(num * ONE_FX, den));
	endfunction

	function automatic longint floor_sqrt(input longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic int dim_of(input int sz);
		if (sz == 0) return 1;
		if (sz > DIM) return DIM;
		return sz;
	endfunction

	// factor, invert the factor, then form the inverse and queue it
	function automatic void predict_inverse(input int n);
		longint s, t, r;
		longint inv [DIM*DIM];
		inv_elem_t e;
		sat_seen = 0;
		npd_seen = 0;
		for (int i = 0; i < n; i++) begin
			s = 0;
			for (int k = 0; k < i; k++) s += fx_mul(chol[k*DIM+i], chol[k*DIM+i]);
			t = clip32(a_mat[i*DIM+i] - s);
			if (t <= 0) begin
				npd_seen = 1;
				chol[i*DIM+i] = 1;
			end else begin
				r = floor_sqrt(t << FRAC);
				chol[i*DIM+i] = r < 1 ? 64'sd1 : clip32(r);
			end
			chol_inv[i*DIM+i] = clip32(round_div(ONE_FX * ONE_FX, chol[i*DIM+i]));
			for (int j = i + 1; j < n; j++) begin
				s = 0;
				for (int k = 0; k < i; k++) s += fx_mul(chol[k*DIM+i], chol[k*DIM+j]);
				chol[i*DIM+j] = fx_div(clip32(a_mat[i*DIM+j] - s), chol[i*DIM+i]);
			end
		end
		for (int i = 0; i < n; i++)
			for (int j = i + 1; j < n; j++) begin
				s = 0;
				for (int k = i; k < j; k++) s += fx_mul(chol_inv[i*DIM+k], chol[k*DIM+j]);
				chol_inv[i*DIM+j] = fx_div(clip32(-s), chol[j*DIM+j]);
			end
		for (int i = 0; i < n; i++)
			for (int j = i; j < n; j++) begin
				s = 0;
				for (int k = j; k < n; k++)
					s += fx_mul(chol_inv[i*DIM+k], chol_inv[j*DIM+k]);
				inv[i*DIM+j] = clip32(s);
				inv[j*DIM+i] = inv[i*DIM+j];
			end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				e.value = csmi_pkg::data_t'(inv[i*DIM+j]);
				e.row   = csmi_pkg::POS_W'(i);
				e.col   = csmi_pkg::POS_W'(j);
				e.last  = (i == n - 1) && (j == n - 1);
				e.npd   = npd_seen;
				e.sat   = sat_seen;
				expected_inverse.push_back(e);
			end
	endfunction

	function automatic void load_element(input csmi_pkg::data_t v);
		int n;
		n = dim_of(size_reg);
		if (loaded >= n * n) loaded = 0;
		a_mat[(loaded / n) * DIM + (loaded % n)] = longint'(v);
		loaded++;
		if (loaded == n * n) begin
			loaded = 0;
			predict_inverse(n);
		end
	endfunction

	// ---------------- drivers ----------------
	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 15);
	endfunction

	// valid is left high after a transfer so back-to-back items stay gapless
	task automatic send_element(input csmi_pkg::data_t v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			elem_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_ch.valid         <= 1'b1;
		elem_ch.element_value <= v;
		do @(posedge clk); while (!elem_ch.ready);
		load_element(v);
		elems_sent++;
	endtask

	task automatic end_burst();
		elem_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_inverse.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_size(input logic [csmi_pkg::SIZE_W-1:0] sz);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.matrix_size <= sz;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		size_reg = sz;
		loaded   = 0;
		@(posedge clk);
	endtask

	// well-conditioned SPD matrix, or raw noise; lower triangle is always noise
	task automatic send_matrix(input int n, input bit spd);
		csmi_pkg::data_t v;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				if (!spd || j < i) v = $urandom;
				else if (i == j)
					v = csmi_pkg::data_t'($urandom_range(32'h0010_0000, 32'h0080_0000)
						+ n * 32'h0008_0000);
				else v = csmi_pkg::data_t'(int'($urandom_range(0, 32'h000F_FFFF))
					- 32'sh0008_0000);
				send_element(v);
			end
	endtask

	// ---------------- result checker ----------------
	initial begin : inverse_sink
		int wait_left;
		inv_elem_t e;
		inv_ch.ready <= 1'b0;
		wait_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (inv_ch.valid && inv_ch.ready) begin
				if (expected_inverse.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					e = expected_inverse.pop_front();
					if (inv_ch.inverse_value !== e.value)
						report_mismatch($sformatf("value %h, want %h at (%0d,%0d)",
							inv_ch.inverse_value, e.value, e.row, e.col));
					if (inv_ch.out_row !== e.row || inv_ch.out_col !== e.col)
						report_mismatch($sformatf("position (%0d,%0d), want (%0d,%0d)",
							inv_ch.out_row, inv_ch.out_col, e.row, e.col));
					if (inv_ch.last_of_run !== e.last)
						report_mismatch("last_of_run wrong");
					if (inv_ch.not_pos_definite !== e.npd)
						report_mismatch("not_pos_definite wrong");
					if (inv_ch.saturated !== e.sat)
						report_mismatch("saturated wrong");
				end
				wait_left = draw_gap();
			end
			if (sink_hold > 0) begin
				sink_hold--;
				inv_ch.ready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				inv_ch.ready <= 1'b0;
			end else begin
				inv_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------- tests ----------------
	task automatic test_reset_size();
		// identity at the reset size of three
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				send_element(i == j ? csmi_pkg::data_t'(ONE_FX) : csmi_pkg::data_t'(0));
		end_burst();
		drain();
	endtask

	task automatic test_scalar_extremes();
		write_size(4'd1);
		send_element(csmi_pkg::data_t'(ONE_FX));
		send_element(32'sh7FFF_FFFF);
		send_element(32'sh8000_0000);   // negative pivot
		send_element(32'sh0000_0000);   // zero pivot
		send_element(32'sh0000_0001);   // tiny pivot, result clips
		send_element(32'shFFFF_FFFF);
		end_burst();
		drain();
		write_size(4'd0);                // zero acts as one
		send_element(32'sh0040_0000);
		end_burst();
		drain();
	endtask

	task automatic test_not_pos_def();
		write_size(4'd2);
		send_element(csmi_pkg::data_t'(ONE_FX));
		send_element(csmi_pkg::data_t'(2 * ONE_FX));
		send_element(32'sh8000_0000);
		send_element(csmi_pkg::data_t'(ONE_FX));
		end_burst();
		drain();
	endtask

	task automatic test_resize_mid_load();
		write_size(4'd3);
		repeat (4) send_element($urandom);
		end_burst();
		drain();
		write_size(4'd2);
		send_matrix(2, 1);
		end_burst();
		drain();
	endtask

	task automatic test_all_sizes();
		for (int sz = 1; sz <= DIM; sz++) begin
			write_size(csmi_pkg::SIZE_W'(sz));
			send_matrix(sz, 1);
			end_burst();
			drain();
		end
		write_size(4'd15);               // above the maximum acts as eight
		send_matrix(DIM, 1);
		end_burst();
		drain();
	endtask

	task automatic test_backpressure();
		write_size(4'd2);
		steady = 1;
		sink_hold = 500;
		repeat (3) send_matrix(2, 1);
		end_burst();
		drain();
		// sender waits for every result before the next matrix
		send_matrix(2, 1);
		end_burst();
		while (expected_inverse.size() != 0) @(posedge clk);
		send_matrix(2, 0);
		end_burst();
		steady = 0;
		drain();
	endtask

	task automatic test_random();
		int sz;
		while (elems_sent < 370) begin
			case ($urandom_range(0, 9))
				0: sz = 0;
				1: sz = $urandom_range(9, 15);
				2: sz = $urandom_range(5, 8);
				default: sz = $urandom_range(1, 4);
			endcase
			if (sz != size_reg) write_size(csmi_pkg::SIZE_W'(sz));
			steady = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(1, 3)) send_matrix(dim_of(sz), $urandom_range(0, 4) != 0);
			end_burst();
			drain();
		end
		steady = 0;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.matrix_size   <= '0;
		elem_ch.valid        <= 1'b0;
		elem_ch.element_value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_scalar_extremes();
		test_not_pos_def();
		test_resize_mid_load();
		test_all_sizes();
		test_backpressure();
		test_random();

		while (expected_inverse.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
